// ===== hdl/skch_pkg.sv =====
package skch_pkg;

  localparam logic [31:0] HASH_SEED = 32'd5381;
  localparam int unsigned REG_BUCKET_ORDER = 0;
  localparam logic [3:0] BUCKET_ORDER_RESET = 4'd8;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_PRESENT   = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_TOO_LONG  = 3'd4;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  key_char;
    logic [15:0] entry_handle;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] found_handle;
    logic [7:0]  bucket_index;
    logic [31:0] hash_value;
  } result_t;

  // one finished key handed from the front to the back
  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] handle;
    logic [31:0] hash;
    logic        too_long;
  } job_t;

endpackage

// ===== hdl/skch_ram.sv =====
module skch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/skch_fifo.sv =====
module skch_fifo
  import skch_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t din,
  input  logic pop,
  output job_t dout,
  output logic empty,
  output logic full
);

  job_t       slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign dout  = slots[rptr];
  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push && !full) begin
        wptr <= ~wptr;
      end
      if (pop && !empty) begin
        rptr <= ~rptr;
      end
      count <= count + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

endmodule

// ===== hdl/skch_front.sv =====
module skch_front
  import skch_pkg::*;
#(
  parameter int MAX_KEY_LEN = 16,
  localparam int LW  = $clog2(MAX_KEY_LEN + 1),
  localparam int KAW = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  item_t          item,
  output logic           busy,
  input  logic           back_ready,
  input  logic           key_done,
  input  logic           q_full,
  output logic           q_push,
  output job_t           q_din,
  output logic [LW-1:0]  key_len,
  input  logic [KAW-1:0] kb_raddr,
  output logic [7:0]     kb_rdata
);

  logic        locked;
  logic        too_long;
  logic [31:0] hash;
  logic [31:0] hash_next;
  logic        accept;
  logic        is_term;
  logic        kb_we;

  assign busy      = locked || !back_ready || q_full;
  assign accept    = start && !busy;
  assign is_term   = (item.key_char == 8'd0);
  assign hash_next = ((hash << 5) + hash) ^ {24'd0, item.key_char};
  assign kb_we     = accept && !is_term && (key_len < LW'(MAX_KEY_LEN));

  assign q_push          = accept && is_term;
  assign q_din.opcode    = item.opcode;
  assign q_din.handle    = item.entry_handle;
  assign q_din.hash      = hash;
  assign q_din.too_long  = too_long;

  skch_ram #(.WIDTH(8), .DEPTH(MAX_KEY_LEN)) u_key_buf (
    .clk   (clk),
    .we    (kb_we),
    .waddr (KAW'(key_len)),
    .wdata (item.key_char),
    .raddr (kb_raddr),
    .rdata (kb_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      locked   <= 1'b0;
      too_long <= 1'b0;
      hash     <= HASH_SEED;
      key_len  <= '0;
    end else begin
      if (key_done) begin
        // back is through with the key buffer: reopen for the next key
        locked   <= 1'b0;
        key_len  <= '0;
        too_long <= 1'b0;
        hash     <= HASH_SEED;
      end else if (accept) begin
        if (is_term) begin
          locked <= 1'b1;
        end else begin
          hash <= hash_next;
          if (key_len < LW'(MAX_KEY_LEN)) begin
            key_len <= key_len + LW'(1);
          end else begin
            too_long <= 1'b1;
          end
        end
      end
    end
  end

endmodule

// ===== hdl/skch_back.sv =====
module skch_back
  import skch_pkg::*;
#(
  parameter int BUCKET_BITS = 8,
  parameter int ENTRY_COUNT = 256,
  parameter int MAX_KEY_LEN = 16,
  localparam int LW  = $clog2(MAX_KEY_LEN + 1),
  localparam int KAW = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1,
  localparam int EIW = $clog2(ENTRY_COUNT),
  localparam int EW  = $clog2(ENTRY_COUNT + 1),
  localparam int CD  = ENTRY_COUNT * MAX_KEY_LEN,
  localparam int CAW = $clog2(CD)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [3:0]     bucket_order,
  input  logic           q_empty,
  input  job_t           q_dout,
  output logic           q_pop,
  input  logic [LW-1:0]  key_len,
  output logic [KAW-1:0] kb_raddr,
  input  logic [7:0]     kb_rdata,
  output logic           key_done,
  output logic           ready,
  output logic           done,
  output result_t        result
);

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_HEAD  = 11'b00000000100,
    S_CHK   = 11'b00000001000,
    S_LEN   = 11'b00000010000,
    S_CMP   = 11'b00000100000,
    S_ACT   = 11'b00001000000,
    S_POP   = 11'b00010000000,
    S_ALLOC = 11'b00100000000,
    S_COPY  = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  localparam logic [EW-1:0] NIL = EW'(ENTRY_COUNT);
  localparam logic [EW-1:0] FULL_COUNT = EW'(ENTRY_COUNT);

  state_t               state;
  job_t                 job;
  logic [BUCKET_BITS-1:0] bucket;
  logic [BUCKET_BITS-1:0] bucket_c;
  logic [BUCKET_BITS-1:0] clr;
  logic [4:0]           order_sat;
  logic [EW-1:0]        head_ent;
  logic [EW-1:0]        cur;
  logic [EW-1:0]        prev;
  logic [EW-1:0]        nxt;
  logic [15:0]          ent_handle;
  logic                 hit;
  logic [LW-1:0]        idx;
  logic [LW-1:0]        idx_inc;
  logic [EIW-1:0]       alloc_e;
  logic [EW-1:0]        free_cnt;
  logic [EW-1:0]        fresh;
  logic [2:0]           status;
  logic [15:0]          found;
  logic [31:0]          bucket_w;

  // memory ports
  logic                   hd_we;
  logic [BUCKET_BITS-1:0] hd_waddr;
  logic [EW-1:0]          hd_wdata;
  logic [BUCKET_BITS-1:0] hd_raddr;
  logic [EW-1:0]          hd_rdata;
  logic                   nx_we;
  logic [EIW-1:0]         nx_waddr;
  logic [EW-1:0]          nx_wdata;
  logic [EW-1:0]          nx_rdata;
  logic [LW-1:0]          ln_rdata;
  logic [15:0]            hl_rdata;
  logic                   ent_we;
  logic                   ch_we;
  logic [CAW-1:0]         ch_waddr;
  logic [CAW-1:0]         ch_raddr;
  logic [7:0]             ch_rdata;
  logic                   fr_we;
  logic [EIW-1:0]         fr_waddr;
  logic [EIW-1:0]         fr_raddr;
  logic [EIW-1:0]         fr_rdata;
  logic [LW-1:0]          rd_idx;

  assign ready    = (state != S_CLEAR);
  assign key_done = (state == S_DONE);
  assign idx_inc  = idx + LW'(1);
  assign q_pop    = (state == S_IDLE) && !q_empty;

  assign order_sat = ({1'b0, bucket_order} > 5'(BUCKET_BITS)) ?
                     5'(BUCKET_BITS) : {1'b0, bucket_order};

  always_comb begin
    for (int b = 0; b < BUCKET_BITS; b++) begin
      bucket_c[b] = q_dout.hash[b] && (5'(b) < order_sat);
    end
  end

  // compare and copy read one character ahead of the counter
  assign rd_idx   = (state == S_LEN || state == S_ALLOC) ? '0 : idx_inc;
  assign kb_raddr = KAW'(rd_idx);
  assign ch_raddr = CAW'(cur[EIW-1:0]) * CAW'(MAX_KEY_LEN) + CAW'(rd_idx);
  assign ch_waddr = CAW'(alloc_e) * CAW'(MAX_KEY_LEN) + CAW'(idx);
  assign ch_we    = (state == S_COPY);
  assign hd_raddr = bucket_c;
  assign fr_raddr = EIW'(free_cnt - EW'(1));
  assign ent_we   = (state == S_ALLOC);

  always_comb begin
    hd_we    = 1'b0;
    hd_waddr = bucket;
    hd_wdata = nxt;
    nx_we    = 1'b0;
    nx_waddr = prev[EIW-1:0];
    nx_wdata = nxt;
    fr_we    = 1'b0;
    fr_waddr = EIW'(free_cnt);
    case (state)
      S_CLEAR: begin
        hd_we    = 1'b1;
        hd_waddr = clr;
        hd_wdata = NIL;
      end
      S_ALLOC: begin
        hd_we    = 1'b1;
        hd_wdata = {{(EW-EIW){1'b0}}, alloc_e};
        nx_we    = 1'b1;
        nx_waddr = alloc_e;
        nx_wdata = head_ent;
      end
      S_ACT: begin
        if (job.opcode == OP_DELETE && hit) begin
          hd_we = (prev == NIL);
          nx_we = (prev != NIL);
          fr_we = (free_cnt < FULL_COUNT);
        end
      end
      default: begin
      end
    endcase
  end

  skch_ram #(.WIDTH(EW), .DEPTH(1 << BUCKET_BITS)) u_heads (
    .clk(clk), .we(hd_we), .waddr(hd_waddr), .wdata(hd_wdata),
    .raddr(hd_raddr), .rdata(hd_rdata)
  );

  skch_ram #(.WIDTH(EW), .DEPTH(ENTRY_COUNT)) u_next (
    .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .raddr(cur[EIW-1:0]), .rdata(nx_rdata)
  );

  skch_ram #(.WIDTH(LW), .DEPTH(ENTRY_COUNT)) u_len (
    .clk(clk), .we(ent_we), .waddr(alloc_e), .wdata(key_len),
    .raddr(cur[EIW-1:0]), .rdata(ln_rdata)
  );

  skch_ram #(.WIDTH(16), .DEPTH(ENTRY_COUNT)) u_handle (
    .clk(clk), .we(ent_we), .waddr(alloc_e), .wdata(job.handle),
    .raddr(cur[EIW-1:0]), .rdata(hl_rdata)
  );

  skch_ram #(.WIDTH(8), .DEPTH(CD)) u_chars (
    .clk(clk), .we(ch_we), .waddr(ch_waddr), .wdata(kb_rdata),
    .raddr(ch_raddr), .rdata(ch_rdata)
  );

  skch_ram #(.WIDTH(EIW), .DEPTH(ENTRY_COUNT)) u_free (
    .clk(clk), .we(fr_we), .waddr(fr_waddr), .wdata(cur[EIW-1:0]),
    .raddr(fr_raddr), .rdata(fr_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr      <= '0;
      free_cnt <= FULL_COUNT;
      fresh    <= FULL_COUNT;
      done     <= 1'b0;
    end else begin
      done <= (state == S_DONE);
      case (state)
        S_CLEAR: begin
          clr <= clr + BUCKET_BITS'(1);
          if (&clr) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!q_empty) begin
            job    <= q_dout;
            bucket <= bucket_c;
            found  <= '0;
            if (q_dout.too_long) begin
              status <= ST_TOO_LONG;
              state  <= S_DONE;
            end else begin
              state <= S_HEAD;
            end
          end
        end
        S_HEAD: begin
          head_ent <= hd_rdata;
          cur      <= hd_rdata;
          prev     <= NIL;
          state    <= S_CHK;
        end
        S_CHK: begin
          if (cur == NIL) begin
            hit   <= 1'b0;
            state <= S_ACT;
          end else begin
            state <= S_LEN;
          end
        end
        S_LEN: begin
          nxt        <= nx_rdata;
          ent_handle <= hl_rdata;
          idx        <= '0;
          if (ln_rdata != key_len) begin
            prev  <= cur;
            cur   <= nx_rdata;
            state <= S_CHK;
          end else if (key_len == '0) begin
            hit   <= 1'b1;
            state <= S_ACT;
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (ch_rdata != kb_rdata) begin
            prev  <= cur;
            cur   <= nxt;
            state <= S_CHK;
          end else if (idx_inc == key_len) begin
            hit   <= 1'b1;
            state <= S_ACT;
          end else begin
            idx <= idx_inc;
          end
        end
        S_ACT: begin
          state  <= S_DONE;
          status <= ST_OK;
          case (job.opcode)
            OP_ADD: begin
              if (hit) begin
                status <= ST_PRESENT;
              end else if (free_cnt == '0) begin
                status <= ST_FULL;
              end else if (free_cnt > fresh) begin
                state <= S_POP;
              end else begin
                alloc_e  <= EIW'(FULL_COUNT - fresh);
                fresh    <= fresh - EW'(1);
                free_cnt <= free_cnt - EW'(1);
                state    <= S_ALLOC;
              end
            end
            OP_DELETE: begin
              if (!hit) begin
                status <= ST_NOT_FOUND;
              end else begin
                found <= ent_handle;
                if (free_cnt < FULL_COUNT) begin
                  free_cnt <= free_cnt + EW'(1);
                end
              end
            end
            default: begin
              if (hit) begin
                found <= ent_handle;
              end else begin
                status <= ST_NOT_FOUND;
              end
            end
          endcase
        end
        S_POP: begin
          alloc_e  <= fr_rdata;
          free_cnt <= free_cnt - EW'(1);
          state    <= S_ALLOC;
        end
        S_ALLOC: begin
          idx   <= '0;
          state <= (key_len == '0) ? S_DONE : S_COPY;
        end
        S_COPY: begin
          idx <= idx_inc;
          if (idx_inc == key_len) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign bucket_w = 32'(bucket);

  always_ff @(posedge clk) begin
    if (state == S_DONE) begin
      result.status       <= status;
      result.found_handle <= found;
      result.bucket_index <= bucket_w[7:0];
      result.hash_value   <= job.hash;
    end
  end

  a_free_above_fresh: assert property (@(posedge clk) disable iff (rst)
    free_cnt >= fresh)
    else $error("free count fell below unused entry count");

  a_free_bounded: assert property (@(posedge clk) disable iff (rst)
    free_cnt <= FULL_COUNT)
    else $error("free count exceeds entry count");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held longer than one cycle");

endmodule

// ===== hdl/string_keyed_chained_hash_table.sv =====
// Key characters are taken one per cycle while busy is low; each one updates
// the hash and is stored in the key buffer. After the terminator the back walks
// the bucket's chain, unless the key was too long, comparing the length and then
// the characters of each entry; an add links a new or a reused freed entry at
// the head of the chain. busy drops with the strobe.
// After reset the bucket heads are cleared at one bucket per cycle
// while busy is high. Results cannot be stalled.
module string_keyed_chained_hash_table
  import skch_pkg::*;
#(
  parameter int BUCKET_BITS = 8,
  parameter int ENTRY_COUNT = 256,
  parameter int MAX_KEY_LEN = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  item_t       item,
  output logic        busy,
  output logic        done,
  output result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int LW  = $clog2(MAX_KEY_LEN + 1);
  localparam int KAW = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;

  logic [3:0]     bucket_order;
  logic           reg_sel;
  logic           q_push;
  logic           q_pop;
  logic           q_empty;
  logic           q_full;
  job_t           q_din;
  job_t           q_dout;
  logic [LW-1:0]  key_len;
  logic [KAW-1:0] kb_raddr;
  logic [7:0]     kb_rdata;
  logic           key_done;
  logic           back_ready;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == 1'(REG_BUCKET_ORDER));
  assign prdata  = reg_sel ? {28'd0, bucket_order} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_order <= BUCKET_ORDER_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      bucket_order <= pwdata[3:0];
    end
  end

  skch_front #(.MAX_KEY_LEN(MAX_KEY_LEN)) u_front (
    .clk(clk), .rst(rst), .start(start), .item(item), .busy(busy),
    .back_ready(back_ready), .key_done(key_done), .q_full(q_full),
    .q_push(q_push), .q_din(q_din), .key_len(key_len),
    .kb_raddr(kb_raddr), .kb_rdata(kb_rdata)
  );

  skch_fifo u_queue (
    .clk(clk), .rst(rst), .push(q_push), .din(q_din), .pop(q_pop),
    .dout(q_dout), .empty(q_empty), .full(q_full)
  );

  skch_back #(
    .BUCKET_BITS(BUCKET_BITS),
    .ENTRY_COUNT(ENTRY_COUNT),
    .MAX_KEY_LEN(MAX_KEY_LEN)
  ) u_back (
    .clk(clk), .rst(rst), .bucket_order(bucket_order),
    .q_empty(q_empty), .q_dout(q_dout), .q_pop(q_pop),
    .key_len(key_len), .kb_raddr(kb_raddr), .kb_rdata(kb_rdata),
    .key_done(key_done), .ready(back_ready), .done(done), .result(result)
  );

endmodule
